### hw/rtl/itr_pkg.sv
// Shared types and constants for the interval timer register block.
// Used by itr_core and interval_timer_registers_top; no dependencies.
package itr_pkg;

   // Field widths
   localparam int ACTION_W     = 2;
   localparam int WORD_INDEX_W = 10;
   localparam int DATA_W       = 32;

   // Stream payload widths; tdata widths padded to whole bytes
   localparam int REQ_TDATA_W  = 48;
   localparam int REQ_TUSER_W  = 2;
   localparam int RSP_TDATA_W  = 40;

   // Configuration port
   localparam int CSR_ADDR_W   = 3;
   localparam logic [DATA_W-1:0] TICK_FREQUENCY_RESET = 32'd1000000;

   // Default identification word
   localparam logic [DATA_W-1:0] DEVICE_ID_DEFAULT = 32'd0;

   // Transaction kinds carried in tuser
   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK  = 2'd0,
      ACT_READ  = 2'd1,
      ACT_WRITE = 2'd2
   } itr_action_type;

   // Register map by word index
   typedef enum logic [2:0] {
      WORD_ID      = 3'd0,
      WORD_RUN     = 3'd1,
      WORD_ONESHOT = 3'd2,
      WORD_LIMIT   = 3'd3,
      WORD_COUNT   = 3'd4,
      WORD_ENABLE  = 3'd5,
      WORD_STATUS  = 3'd6,
      WORD_FREQ    = 3'd7
   } itr_word_type;

   // CSR register indexes
   typedef enum logic [0:0] {
      CSR_TICK_FREQUENCY = 1'b0
   } itr_csr_type;

   // One request transaction
   typedef struct packed {
      itr_action_type          action;
      logic [WORD_INDEX_W-1:0] word_index;
      logic [DATA_W-1:0]       write_data;
   } itr_item_type;

   // One response transaction
   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              irq;
      logic              bad_access;
   } itr_result_type;

endpackage

### hw/rtl/itr_core.sv
// Timer state and register decode for the interval timer block.
// Depends on itr_pkg; instantiated by interval_timer_registers_top.
module itr_core
   import itr_pkg::*;
#(
   parameter logic [DATA_W-1:0] DEVICE_ID = DEVICE_ID_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  itr_item_type      item,
   input  logic [DATA_W-1:0] tick_frequency,
   output itr_result_type    result
);

   logic              run_ff, run_in;
   logic              oneshot_ff, oneshot_in;
   logic [DATA_W-1:0] limit_ff, limit_in;
   logic [DATA_W-1:0] count_ff, count_in;
   logic              pending_ff, pending_in;
   logic              enable_ff, enable_in;
   logic [DATA_W-1:0] rd_data;
   logic              bad;
   logic              word_ok;
   itr_word_type      word;

   assign word_ok = (item.word_index[WORD_INDEX_W-1:3] == '0);
   assign word    = itr_word_type'(item.word_index[2:0]);

   // Compute next state and the response for the transaction in the input stage
   always_comb begin
      run_in     = run_ff;
      oneshot_in = oneshot_ff;
      limit_in   = limit_ff;
      count_in   = count_ff;
      pending_in = pending_ff;
      enable_in  = enable_ff;
      rd_data    = '0;
      bad        = 1'b0;
      unique case (item.action)
         ACT_TICK: begin
            if (run_ff) begin
               if (count_ff <= DATA_W'(1)) begin
                  // expire: flag it, then reload or stop
                  pending_in = 1'b1;
                  if (oneshot_ff) begin
                     run_in   = 1'b0;
                     count_in = '0;
                  end else begin
                     count_in = limit_ff;
                  end
               end else begin
                  count_in = count_ff - DATA_W'(1);
               end
            end
         end
         ACT_READ: begin
            if (!word_ok) begin
               bad = 1'b1;
            end else begin
               unique case (word)
                  WORD_ID:      rd_data = DEVICE_ID;
                  WORD_RUN:     rd_data = DATA_W'(run_ff);
                  WORD_ONESHOT: rd_data = DATA_W'(oneshot_ff);
                  WORD_LIMIT:   rd_data = limit_ff;
                  WORD_COUNT:   rd_data = count_ff;
                  WORD_ENABLE:  rd_data = DATA_W'(enable_ff);
                  WORD_STATUS:  rd_data = DATA_W'(pending_ff);
                  WORD_FREQ:    rd_data = tick_frequency;
                  default:      bad = 1'b1;
               endcase
            end
         end
         ACT_WRITE: begin
            if (!word_ok) begin
               bad = 1'b1;
            end else begin
               unique case (word)
                  WORD_RUN:     run_in = (item.write_data != '0);
                  WORD_ONESHOT: oneshot_in = (item.write_data != '0);
                  WORD_LIMIT: begin
                     limit_in = item.write_data;
                     count_in = item.write_data;
                  end
                  WORD_COUNT:   count_in = item.write_data;
                  WORD_ENABLE:  enable_in = (item.write_data != '0);
                  WORD_STATUS: begin
                     // write one to clear
                     if (item.write_data[0]) pending_in = 1'b0;
                  end
                  default:      bad = 1'b1;  // ID and frequency are read only
               endcase
            end
         end
         default: ;  // unused kind: no effect
      endcase
      result.read_data  = rd_data;
      result.irq        = pending_in & enable_in;
      result.bad_access = bad;
   end

   // Hold timer state; advance only when the input stage retires
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= 1'b0;
         oneshot_ff <= 1'b0;
         limit_ff   <= '0;
         count_ff   <= '0;
         pending_ff <= 1'b0;
         enable_ff  <= 1'b0;
      end else if (step_en) begin
         run_ff     <= run_in;
         oneshot_ff <= oneshot_in;
         limit_ff   <= limit_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
         enable_ff  <= enable_in;
      end
   end

`ifndef SYNTHESIS
   a_tick_decrement: assert property (@(posedge clock) disable iff (reset)
      (step_en && item.action == ACT_TICK && run_ff && count_ff > DATA_W'(1))
      |=> (count_ff == $past(count_ff) - DATA_W'(1)))
      else $error("tick did not decrement the count");

   a_expire_sets_pending: assert property (@(posedge clock) disable iff (reset)
      (step_en && item.action == ACT_TICK && run_ff && count_ff <= DATA_W'(1))
      |=> pending_ff)
      else $error("expiry did not set the status bit");

   a_oneshot_stops: assert property (@(posedge clock) disable iff (reset)
      (step_en && item.action == ACT_TICK && run_ff && oneshot_ff
       && count_ff <= DATA_W'(1))
      |=> (!run_ff && count_ff == '0))
      else $error("one-shot expiry did not stop the timer");

   a_idle_holds_state: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> ($stable(count_ff) && $stable(run_ff) && $stable(pending_ff)))
      else $error("timer state changed without a transaction");

   a_limit_loads_count: assert property (@(posedge clock) disable iff (reset)
      (step_en && item.action == ACT_WRITE && word_ok && word == WORD_LIMIT)
      |=> (limit_ff == count_ff))
      else $error("limit write did not load the count");
`endif

endmodule

### hw/rtl/interval_timer_registers_top.sv
// Top level of the interval timer register block: stream channels, CSR port,
// input stage and response register. Depends on itr_pkg and itr_core.
//
// Usage:
//   req_*  carries one transaction per handshake: tuser holds the kind
//          (tick, register read, register write), tdata the word index and
//          write data. A tick decrements the running timer or expires it.
//   rsp_*  returns exactly one transaction per request, in order: read data,
//          the interrupt line after the request, and a bad-access flag.
//   csr_*  APB-style port holding the tick frequency register at address 0,
//          returned by reads of timer word 7.
// Each request waits in the input stage; its result is registered in the response
// register once that is free or draining. One request is accepted every cycle unless
// the receiver stalls, set by the single input stage feeding timer and response register.
// Synchronous reset empties both stages, stops the timer, clears all timer
// registers and restores the frequency to its default.
// When the receiver stalls, the response register holds and the input stage
// still takes one more request; after that req_tready drops until the
// response is taken.
module interval_timer_registers_top
   import itr_pkg::*;
#(
   parameter logic [DATA_W-1:0] DEVICE_ID = DEVICE_ID_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [9:0] word_index, [41:10] write_data
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // [1:0] action
   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // [31:0] read_data, [32] irq, [33] bad_access
   // configuration port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [DATA_W-1:0]      csr_pwdata,
   output logic [DATA_W-1:0]      csr_prdata,
   output logic                   csr_pready
);

   logic           s1_valid_ff;
   itr_item_type   s1_item_ff;
   logic           rsp_valid_ff;
   itr_result_type rsp_data_ff;
   logic [DATA_W-1:0] freq_ff;
   logic           s1_adv;
   logic           csr_wr;
   itr_csr_type    csr_reg;
   itr_result_type core_result;

   // Retire the input stage when the response register is free or draining
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_item_ff.action     <= itr_action_type'(req_tuser);
         s1_item_ff.word_index <= req_tdata[WORD_INDEX_W-1:0];
         s1_item_ff.write_data <= req_tdata[WORD_INDEX_W+DATA_W-1:WORD_INDEX_W];
      end
   end

   itr_core #(
      .DEVICE_ID(DEVICE_ID)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .step_en        (s1_adv),
      .item           (s1_item_ff),
      .tick_frequency (freq_ff),
      .result         (core_result)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-DATA_W-2){1'b0}}, rsp_data_ff.bad_access,
                        rsp_data_ff.irq, rsp_data_ff.read_data};

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_reg    = itr_csr_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= TICK_FREQUENCY_RESET;
      end else if (csr_wr && csr_reg == CSR_TICK_FREQUENCY) begin
         freq_ff <= csr_pwdata;
      end
   end

   always_comb begin
      unique case (csr_reg)
         CSR_TICK_FREQUENCY: csr_prdata = freq_ff;
         default:            csr_prdata = '0;
      endcase
   end

endmodule
